// ===== rtl/vfc_pkg.sv =====
// shared types and constants for the voxel face culling core
package vfc_pkg;

  localparam int IN_DATA_W  = 24;
  localparam int IN_USER_W  = 2;
  localparam int OUT_DATA_W = 88;
  localparam int CFG_IDX_W  = 2;
  localparam int CFG_DATA_W = 16;
  localparam int WORLD_W    = 20;
  localparam int QUAD_W     = 15;
  localparam int BASE_W     = 17;
  localparam int BLOCK_W    = 8;

  typedef enum logic [1:0] {
    CMD_LOAD_VOXEL = 2'd0,
    CMD_LOAD_BOUND = 2'd1,
    CMD_MESH       = 2'd2,
    CMD_CLEAR      = 2'd3
  } cmd_t;

  typedef enum logic [1:0] {
    CFG_CHUNK_X  = 2'd0,
    CFG_CHUNK_Y  = 2'd1,
    CFG_CHUNK_Z  = 2'd2,
    CFG_NEIGHBOR = 2'd3
  } cfg_idx_t;

  localparam logic [2:0] FACE_PX = 3'd0;
  localparam logic [2:0] FACE_NX = 3'd1;
  localparam logic [2:0] FACE_PY = 3'd2;
  localparam logic [2:0] FACE_NY = 3'd3;
  localparam logic [2:0] FACE_PZ = 3'd4;
  localparam logic [2:0] FACE_NZ = 3'd5;

  typedef enum logic [1:0] {
    ST_IDLE,
    ST_LOOK,
    ST_EMIT
  } state_t;

  // what the read in flight returns
  typedef enum logic [1:0] {
    LK_CENTER,
    LK_VOXEL,
    LK_BOUND,
    LK_ABSENT
  } lookup_t;

endpackage

// ===== rtl/vfc_ram.sv =====
// generic single write port, single read port ram with registered read
module vfc_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 4096
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] waddr,
  input  logic [WIDTH-1:0]         wdata,
  input  logic [$clog2(DEPTH)-1:0] raddr,
  output logic [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata <= mem[raddr];
  end

endmodule

// ===== rtl/voxel_face_culling_core.sv =====
// voxel face culling core: chunk store, boundary flags and face emitter
//
// Loads of voxels and boundary flags and the quad counter clear each complete
// as the command is accepted. A mesh command is accepted, then the centre voxel
// and its six neighbours are read one after another through the single read
// port of the voxel (or boundary) memory, then each visible face is emitted in
// turn while the result side takes transfers. The input stays blocked until the
// last visible face is emitted, or until the lookups end when the voxel is
// empty or fully hidden. The last face of a command waits in the output
// register while the next command is taken.
module voxel_face_culling_core #(
  parameter int SIDE    = 16,
  parameter int ID_BITS = 8
) (
  input  logic                           clk,
  input  logic                           rst,
  // config write port
  input  logic                           cfg_we,
  input  logic [vfc_pkg::CFG_IDX_W-1:0]  cfg_index,
  input  logic [vfc_pkg::CFG_DATA_W-1:0] cfg_wdata,
  // command stream
  input  logic                           s_axis_tvalid,
  output logic                           s_axis_tready,
  // pos_x[3:0], pos_y[7:4], pos_z[11:8], voxel_value[19:12], side_sel[22:20],
  // empty_flag[23]
  input  logic [vfc_pkg::IN_DATA_W-1:0]  s_axis_tdata,
  // cmd[1:0]
  input  logic [vfc_pkg::IN_USER_W-1:0]  s_axis_tuser,
  // face stream
  output logic                           m_axis_tvalid,
  input  logic                           m_axis_tready,
  // world_x[19:0], world_y[39:20], world_z[59:40], face_dir[62:60],
  // block_id[70:63], base_vertex[87:71]
  output logic [vfc_pkg::OUT_DATA_W-1:0] m_axis_tdata,
  output logic                           m_axis_tlast
);

  import vfc_pkg::*;

  localparam int PLANE = SIDE * SIDE;
  localparam int VOL   = SIDE * SIDE * SIDE;
  localparam int VAW   = $clog2(VOL);
  localparam int BAW   = $clog2(6 * PLANE);

  function automatic logic [VAW-1:0] vox_addr(input logic [4:0] a, input logic [4:0] b,
                                              input logic [4:0] c);
    return VAW'(32'(a) * PLANE + 32'(b) * SIDE + 32'(c));
  endfunction

  function automatic logic [BAW-1:0] bnd_addr(input logic [2:0] s, input logic [4:0] a,
                                              input logic [4:0] b);
    return BAW'(32'(s) * PLANE + 32'(a) * SIDE + 32'(b));
  endfunction

  // input fields
  logic [3:0]  in_x, in_y, in_z;
  logic [7:0]  in_value;
  logic [2:0]  in_side;
  logic        in_flag;
  cmd_t        in_cmd;
  logic        in_fire;
  logic        x_ok, y_ok, z_ok;

  assign in_x     = s_axis_tdata[3:0];
  assign in_y     = s_axis_tdata[7:4];
  assign in_z     = s_axis_tdata[11:8];
  assign in_value = s_axis_tdata[19:12];
  assign in_side  = s_axis_tdata[22:20];
  assign in_flag  = s_axis_tdata[23];
  assign in_cmd   = cmd_t'(s_axis_tuser);
  assign in_fire  = s_axis_tvalid && s_axis_tready;

  assign x_ok = 32'(in_x) < SIDE;
  assign y_ok = 32'(in_y) < SIDE;
  assign z_ok = 32'(in_z) < SIDE;

  // config registers
  logic [15:0] chunk_x, chunk_y, chunk_z;
  logic [5:0]  neighbor_present;

  always_ff @(posedge clk) begin
    if (rst) begin
      chunk_x          <= '0;
      chunk_y          <= '0;
      chunk_z          <= '0;
      neighbor_present <= '0;
    end else if (cfg_we) begin
      case (cfg_idx_t'(cfg_index))
        CFG_CHUNK_X:  chunk_x          <= cfg_wdata;
        CFG_CHUNK_Y:  chunk_y          <= cfg_wdata;
        CFG_CHUNK_Z:  chunk_z          <= cfg_wdata;
        CFG_NEIGHBOR: neighbor_present <= cfg_wdata[5:0];
        default: ;
      endcase
    end
  end

  // control state
  state_t       state, state_next;
  logic [2:0]   step;
  lookup_t      lk_kind;
  logic [2:0]   lk_side;
  logic [5:0]   vis_mask;
  logic [QUAD_W-1:0] quad_count;
  logic         out_valid;

  // held command payload
  logic [3:0]         hx, hy, hz;
  logic [ID_BITS-1:0] center_id;

  // memories
  logic               vox_we;
  logic [VAW-1:0]     vox_waddr, vox_raddr;
  logic [ID_BITS-1:0] vox_rdata;
  logic               bnd_we;
  logic [BAW-1:0]     bnd_waddr, bnd_raddr;
  logic [0:0]         bnd_rdata;
  logic [4:0]         bnd_wa, bnd_wb;

  vfc_ram #(.WIDTH(ID_BITS), .DEPTH(VOL)) u_voxel_ram (
    .clk   (clk),
    .we    (vox_we),
    .waddr (vox_waddr),
    .wdata (ID_BITS'(in_value)),
    .raddr (vox_raddr),
    .rdata (vox_rdata)
  );

  vfc_ram #(.WIDTH(1), .DEPTH(6 * PLANE)) u_bound_ram (
    .clk   (clk),
    .we    (bnd_we),
    .waddr (bnd_waddr),
    .wdata (in_flag),
    .raddr (bnd_raddr),
    .rdata (bnd_rdata)
  );

  // load side
  always_comb begin
    if (in_side inside {FACE_PX, FACE_NX}) begin
      bnd_wa = {1'b0, in_y};
      bnd_wb = {1'b0, in_z};
    end else if (in_side inside {FACE_PY, FACE_NY}) begin
      bnd_wa = {1'b0, in_x};
      bnd_wb = {1'b0, in_z};
    end else begin
      bnd_wa = {1'b0, in_x};
      bnd_wb = {1'b0, in_y};
    end
  end

  assign vox_waddr = vox_addr({1'b0, in_x}, {1'b0, in_y}, {1'b0, in_z});
  assign bnd_waddr = bnd_addr(in_side, bnd_wa, bnd_wb);
  assign vox_we    = in_fire && (in_cmd == CMD_LOAD_VOXEL) && x_ok && y_ok && z_ok;

  always_comb begin
    bnd_we = 1'b0;
    if (in_fire && (in_cmd == CMD_LOAD_BOUND)) begin
      if (in_side inside {FACE_PX, FACE_NX}) begin
        bnd_we = y_ok && z_ok;
      end else if (in_side inside {FACE_PY, FACE_NY}) begin
        bnd_we = x_ok && z_ok;
      end else if (in_side inside {FACE_PZ, FACE_NZ}) begin
        bnd_we = x_ok && y_ok;
      end
    end
  end

  // lookup issue: step 0 reads the centre, steps 1 to 6 one neighbour each
  logic [4:0] hx_w, hy_w, hz_w, hx_p, hy_p, hz_p, hx_m, hy_m, hz_m;
  logic [4:0] nb_x, nb_y, nb_z, pl_a, pl_b;
  logic       nb_inside;
  logic [2:0] iss_side;
  lookup_t    iss_kind;

  assign hx_w = {1'b0, hx};
  assign hy_w = {1'b0, hy};
  assign hz_w = {1'b0, hz};
  assign hx_p = hx_w + 5'd1;
  assign hy_p = hy_w + 5'd1;
  assign hz_p = hz_w + 5'd1;
  assign hx_m = hx_w - 5'd1;
  assign hy_m = hy_w - 5'd1;
  assign hz_m = hz_w - 5'd1;
  assign iss_side = step - 3'd1;

  always_comb begin
    nb_x      = hx_w;
    nb_y      = hy_w;
    nb_z      = hz_w;
    pl_a      = hy_w;
    pl_b      = hz_w;
    nb_inside = 1'b1;
    case (step)
      3'd1: begin
        nb_x      = hx_p;
        nb_inside = 32'(hx_p) < SIDE;
      end
      3'd2: begin
        nb_x      = hx_m;
        nb_inside = hx != 4'd0;
      end
      3'd3: begin
        nb_y      = hy_p;
        pl_a      = hx_w;
        nb_inside = 32'(hy_p) < SIDE;
      end
      3'd4: begin
        nb_y      = hy_m;
        pl_a      = hx_w;
        nb_inside = hy != 4'd0;
      end
      3'd5: begin
        nb_z      = hz_p;
        pl_a      = hx_w;
        pl_b      = hy_w;
        nb_inside = 32'(hz_p) < SIDE;
      end
      3'd6: begin
        nb_z      = hz_m;
        pl_a      = hx_w;
        pl_b      = hy_w;
        nb_inside = hz != 4'd0;
      end
      default: ;
    endcase
  end

  assign vox_raddr = vox_addr(nb_x, nb_y, nb_z);
  assign bnd_raddr = bnd_addr(iss_side, pl_a, pl_b);

  always_comb begin
    if (step == 3'd0) begin
      iss_kind = LK_CENTER;
    end else if (nb_inside) begin
      iss_kind = LK_VOXEL;
    end else if (neighbor_present[iss_side]) begin
      iss_kind = LK_BOUND;
    end else begin
      iss_kind = LK_ABSENT;
    end
  end

  // visibility of the lookup returning this cycle
  logic       lk_vis;
  logic [5:0] lk_bit, mask_final;

  always_comb begin
    case (lk_kind)
      LK_VOXEL:  lk_vis = vox_rdata == '0;
      LK_BOUND:  lk_vis = bnd_rdata[0];
      LK_ABSENT: lk_vis = 1'b1;
      default:   lk_vis = 1'b0;
    endcase
  end

  assign lk_bit     = (lk_kind != LK_CENTER && lk_vis) ? (6'd1 << lk_side) : 6'd0;
  assign mask_final = vis_mask | lk_bit;

  // face selection: lowest visible side first
  logic [2:0] sel_side;
  logic [5:0] mask_rest;
  logic       emit_fire;

  always_comb begin
    sel_side = FACE_PX;
    for (int i = 5; i >= 0; i--) begin
      if (vis_mask[i]) begin
        sel_side = 3'(i);
      end
    end
  end

  assign mask_rest = vis_mask & ~(6'd1 << sel_side);

  // next state
  always_comb begin
    state_next = state;
    case (state)
      ST_IDLE: begin
        if (in_fire && in_cmd == CMD_MESH && x_ok && y_ok && z_ok) begin
          state_next = ST_LOOK;
        end
      end
      ST_LOOK: begin
        if (step == 3'd7) begin
          state_next = (center_id != '0 && mask_final != 6'd0) ? ST_EMIT : ST_IDLE;
        end
      end
      ST_EMIT: begin
        if (emit_fire && mask_rest == 6'd0) begin
          state_next = ST_IDLE;
        end
      end
      default: state_next = ST_IDLE;
    endcase
  end

  // state outputs
  always_comb begin
    s_axis_tready = 1'b0;
    emit_fire     = 1'b0;
    case (state)
      ST_IDLE: s_axis_tready = 1'b1;
      ST_EMIT: emit_fire     = !out_valid || m_axis_tready;
      default: ;
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state      <= ST_IDLE;
      step       <= '0;
      lk_kind    <= LK_CENTER;
      lk_side    <= '0;
      vis_mask   <= '0;
      quad_count <= '0;
      out_valid  <= 1'b0;
    end else begin
      state <= state_next;
      if (state == ST_IDLE) begin
        step     <= '0;
        vis_mask <= '0;
      end else if (state == ST_LOOK) begin
        step     <= step + 3'd1;
        lk_kind  <= iss_kind;
        lk_side  <= iss_side;
        if (step != 3'd0) begin
          vis_mask <= mask_final;
        end
      end else if (emit_fire) begin
        vis_mask <= mask_rest;
      end
      if (in_fire && in_cmd == CMD_CLEAR) begin
        quad_count <= '0;
      end else if (emit_fire) begin
        quad_count <= quad_count + 1'b1;
      end
      if (emit_fire) begin
        out_valid <= 1'b1;
      end else if (m_axis_tready) begin
        out_valid <= 1'b0;
      end
    end
  end

  // payload
  logic [WORLD_W-1:0] world_x, world_y, world_z;
  logic [2:0]         face_dir;
  logic [BLOCK_W-1:0] block_id;
  logic [BASE_W-1:0]  base_vertex;
  logic               last;

  always_ff @(posedge clk) begin
    if (in_fire) begin
      hx <= in_x;
      hy <= in_y;
      hz <= in_z;
    end
    if (state == ST_LOOK && step != 3'd0 && lk_kind == LK_CENTER) begin
      center_id <= vox_rdata;
    end
    if (emit_fire) begin
      // chunk times side wraps to the world width
      world_x     <= {{(WORLD_W-16){chunk_x[15]}}, chunk_x} * WORLD_W'(SIDE)
                     + WORLD_W'(hx);
      world_y     <= {{(WORLD_W-16){chunk_y[15]}}, chunk_y} * WORLD_W'(SIDE)
                     + WORLD_W'(hy);
      world_z     <= {{(WORLD_W-16){chunk_z[15]}}, chunk_z} * WORLD_W'(SIDE)
                     + WORLD_W'(hz);
      face_dir    <= sel_side;
      block_id    <= BLOCK_W'(center_id);
      base_vertex <= {quad_count, 2'b00};
      last        <= mask_rest == 6'd0;
    end
  end

  assign m_axis_tvalid = out_valid;
  assign m_axis_tdata  = {base_vertex, block_id, face_dir, world_z, world_y, world_x};
  assign m_axis_tlast  = last;

endmodule
